// ===== hdl/aoqs_pkg.sv =====
// Shared types, codes and constants for the box overlap query store.
package aoqs_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t hi_z;
    coord_t hi_y;
    coord_t hi_x;
    coord_t lo_z;
    coord_t lo_y;
    coord_t lo_x;
  } box_t;

  typedef struct packed {
    logic [31:0] id;
    logic        moving;
    box_t        box;
  } entry_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic id_eq;
    logic overlap;
    box_t merged;
  } cmp_t;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_SET    = 3'd2,
    MODE_MERGE  = 3'd3,
    MODE_BOXQ   = 3'd4,
    MODE_OBJQ   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_HIT      = 3'd4,
    ST_NOHITS   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_QUERY,
    S_RESP
  } state_t;

endpackage

// ===== hdl/aabb_overlap_query_store_unit.sv =====
// Top level of the box overlap query store: sequencer, table and compare unit.
//
// Input channel in_*: one item per command (add, remove, set box, merge box,
// box query, object query). in_tready is high only while the block is idle;
// each item is worked on alone until its last result is in the output register.
// Result channel out_*: one item per result, out_tlast on the final one.
// A query gives one hit item per overlapping entry in table order (an object
// query skips its own entry), a single no-hits item, or a not-found item.
// The table read port gives one entry per cycle while no stalled result
// blocks a query scan. A find of an id reads entries in table order until
// the id matches or the table ends. Remove then compacts the table by
// moving each later entry down, then responds. A box query scans every
// entry; an object query scans after its find. Add, set and merge respond
// after their find.
// A stalled receiver holds the output register; the scan pauses on the next
// hit that needs the register and resumes when it drains.
// Reset (rst_n low, synchronous) empties the table and drops any pending item.
module aabb_overlap_query_store_unit #(
  parameter int MAX_ENTRIES = aoqs_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // object_id[31:0], min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  input  logic [223:0] in_tdata,
  // mode[2:0], moving[3]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_id[31:0]
  output logic [31:0]  out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  aoqs_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     e_r, e_nxt, cnt_r, cnt_nxt, skip_r, skip_nxt;
  logic              skip_en_r, skip_en_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [31:0]       id_r, id_nxt;
  logic              mv_r, mv_nxt;
  aoqs_pkg::box_t    box_r, box_nxt;
  logic              pend_r, pend_nxt;
  logic [31:0]       pend_id_r, pend_id_nxt;
  aoqs_pkg::status_t resp_r, resp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic              we;
  logic [AW-1:0]     waddr, rd_addr;
  aoqs_pkg::entry_t  wdata, rd_ent;
  aoqs_pkg::cmp_t    cmp;

  logic              accept, can_push, scan_end, hit;
  logic [CW-1:0]     e_inc, e_dec;
  logic [2:0]        in_mode;

  assign in_mode  = in_tuser[2:0];
  assign accept   = in_tvalid && in_tready;
  assign can_push = !out_valid_r || out_tready;
  assign scan_end = (e_r >= cnt_r);
  assign e_inc    = e_r + 1'b1;
  assign e_dec    = e_r - 1'b1;
  assign hit      = cmp.overlap && !(skip_en_r && (e_r == skip_r));

  aoqs_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_ent)
  );

  aoqs_cmp u_cmp (
    .ent (rd_ent),
    .q   (box_r),
    .id  (id_r),
    .res (cmp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aoqs_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode > aoqs_pkg::MODE_OBJQ) state_nxt = aoqs_pkg::S_RESP;
          else if (in_mode == aoqs_pkg::MODE_BOXQ) state_nxt = aoqs_pkg::S_QUERY;
          else state_nxt = aoqs_pkg::S_FIND;
        end
      end
      aoqs_pkg::S_FIND: begin
        if (scan_end) begin
          state_nxt = aoqs_pkg::S_RESP;
        end else if (cmp.id_eq) begin
          if (mode_r == aoqs_pkg::MODE_REMOVE) state_nxt = aoqs_pkg::S_SHIFT;
          else if (mode_r == aoqs_pkg::MODE_OBJQ) state_nxt = aoqs_pkg::S_QUERY;
          else state_nxt = aoqs_pkg::S_RESP;
        end
      end
      aoqs_pkg::S_SHIFT: begin
        if (scan_end) state_nxt = aoqs_pkg::S_RESP;
      end
      aoqs_pkg::S_QUERY: begin
        if (scan_end && can_push) state_nxt = aoqs_pkg::S_IDLE;
      end
      aoqs_pkg::S_RESP: begin
        if (can_push) state_nxt = aoqs_pkg::S_IDLE;
      end
      default: state_nxt = aoqs_pkg::S_IDLE;
    endcase
  end

  // Datapath control and result push
  always_comb begin
    e_nxt          = e_r;
    cnt_nxt        = cnt_r;
    skip_nxt       = skip_r;
    skip_en_nxt    = skip_en_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    mv_nxt         = mv_r;
    box_nxt        = box_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    resp_nxt       = resp_r;
    rd_addr        = e_r[AW-1:0];
    we             = 1'b0;
    waddr          = e_r[AW-1:0];
    wdata          = rd_ent;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      aoqs_pkg::S_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          mode_nxt    = in_mode;
          id_nxt      = in_tdata[31:0];
          mv_nxt      = in_tuser[3];
          box_nxt     = in_tdata[223:32];
          e_nxt       = '0;
          skip_en_nxt = 1'b0;
          pend_nxt    = 1'b0;
          resp_nxt    = aoqs_pkg::ST_DONE;
        end
      end
      aoqs_pkg::S_FIND: begin
        if (scan_end) begin
          if (mode_r == aoqs_pkg::MODE_ADD) begin
            if (cnt_r >= MAX_CNT) begin
              resp_nxt = aoqs_pkg::ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = cnt_r[AW-1:0];
              wdata    = '{id: id_r, moving: mv_r, box: box_r};
              cnt_nxt  = cnt_r + 1'b1;
              resp_nxt = aoqs_pkg::ST_DONE;
            end
          end else begin
            resp_nxt = aoqs_pkg::ST_NOTFOUND;
          end
        end else if (cmp.id_eq) begin
          resp_nxt = aoqs_pkg::ST_DONE;
          unique case (mode_r)
            aoqs_pkg::MODE_ADD: resp_nxt = aoqs_pkg::ST_DUP;
            aoqs_pkg::MODE_REMOVE: begin
              e_nxt   = e_inc;
              rd_addr = e_inc[AW-1:0];
            end
            aoqs_pkg::MODE_SET: begin
              we    = 1'b1;
              wdata = '{id: rd_ent.id, moving: rd_ent.moving, box: box_r};
            end
            aoqs_pkg::MODE_MERGE: begin
              we    = rd_ent.moving;
              wdata = '{id: rd_ent.id, moving: rd_ent.moving, box: cmp.merged};
            end
            aoqs_pkg::MODE_OBJQ: begin
              box_nxt     = rd_ent.box;
              skip_nxt    = e_r;
              skip_en_nxt = 1'b1;
              e_nxt       = '0;
              rd_addr     = '0;
            end
            default: ;
          endcase
        end else begin
          e_nxt   = e_inc;
          rd_addr = e_inc[AW-1:0];
        end
      end
      aoqs_pkg::S_SHIFT: begin
        // Move each later entry down by one
        if (scan_end) begin
          cnt_nxt  = cnt_r - 1'b1;
          resp_nxt = aoqs_pkg::ST_DONE;
        end else begin
          we      = 1'b1;
          waddr   = e_dec[AW-1:0];
          e_nxt   = e_inc;
          rd_addr = e_inc[AW-1:0];
        end
      end
      aoqs_pkg::S_QUERY: begin
        // Hold one hit back so the final one can carry last
        if (scan_end) begin
          if (can_push) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pend_r ? aoqs_pkg::ST_HIT : aoqs_pkg::ST_NOHITS;
            out_id_nxt     = pend_r ? pend_id_r : 32'd0;
            out_last_nxt   = 1'b1;
            pend_nxt       = 1'b0;
          end
        end else if (!(hit && pend_r && !can_push)) begin
          if (hit && pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = aoqs_pkg::ST_HIT;
            out_id_nxt     = pend_id_r;
            out_last_nxt   = 1'b0;
          end
          if (hit) begin
            pend_nxt    = 1'b1;
            pend_id_nxt = rd_ent.id;
          end
          e_nxt   = e_inc;
          rd_addr = e_inc[AW-1:0];
        end
      end
      aoqs_pkg::S_RESP: begin
        if (can_push) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_id_nxt     = 32'd0;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aoqs_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      skip_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      skip_en_r   <= skip_en_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    skip_r       <= skip_nxt;
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    mv_r         <= mv_nxt;
    box_r        <= box_nxt;
    pend_id_r    <= pend_id_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_tready  = (state_r == aoqs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("ready again right after accept");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aoqs_pkg::S_SHIFT) |-> (cnt_r != '0))
    else $error("compacting an empty table");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");
`endif

endmodule

// ===== hdl/aoqs_table.sv =====
// Entry table memory: one write port, one read port with registered data.
module aoqs_table #(
  parameter int DEPTH = aoqs_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  aoqs_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output aoqs_pkg::entry_t     rdata
);

  aoqs_pkg::entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/aoqs_cmp.sv =====
// Shared compare unit: id match, three-axis overlap and box union.
module aoqs_cmp (
  input  aoqs_pkg::entry_t ent,
  input  aoqs_pkg::box_t   q,
  input  logic [31:0]      id,
  output aoqs_pkg::cmp_t   res
);

  // Match id and test overlap against the query box
  assign res.id_eq   = (ent.id == id);
  assign res.overlap = (ent.box.lo_x <= q.hi_x) && (ent.box.hi_x > q.lo_x) &&
                       (ent.box.lo_y <= q.hi_y) && (ent.box.hi_y > q.lo_y) &&
                       (ent.box.lo_z <= q.hi_z) && (ent.box.hi_z > q.lo_z);

  // Widen the stored box to cover the query box
  assign res.merged.lo_x = (q.lo_x < ent.box.lo_x) ? q.lo_x : ent.box.lo_x;
  assign res.merged.lo_y = (q.lo_y < ent.box.lo_y) ? q.lo_y : ent.box.lo_y;
  assign res.merged.lo_z = (q.lo_z < ent.box.lo_z) ? q.lo_z : ent.box.lo_z;
  assign res.merged.hi_x = (q.hi_x > ent.box.hi_x) ? q.hi_x : ent.box.hi_x;
  assign res.merged.hi_y = (q.hi_y > ent.box.hi_y) ? q.hi_y : ent.box.hi_y;
  assign res.merged.hi_z = (q.hi_z > ent.box.hi_z) ? q.hi_z : ent.box.hi_z;

endmodule
